// File: src/c6502x_pkg.sv
`default_nettype none
package c6502x_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0, OP_AND = 6'd1, OP_ASL = 6'd2, OP_BCC = 6'd3, OP_BCS = 6'd4,
		OP_BEQ = 6'd5, OP_BIT = 6'd6, OP_BMI = 6'd7, OP_BNE = 6'd8, OP_BPL = 6'd9,
		OP_BRK = 6'd10, OP_BVC = 6'd11, OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14,
		OP_CLI = 6'd15, OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
		OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23, OP_INC = 6'd24,
		OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27, OP_JSR = 6'd28, OP_LDA = 6'd29,
		OP_LDX = 6'd30, OP_LDY = 6'd31, OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34,
		OP_PHA = 6'd35, OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
		OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43, OP_SEC = 6'd44,
		OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47, OP_STX = 6'd48, OP_STY = 6'd49,
		OP_TAX = 6'd50, OP_TAY = 6'd51, OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54,
		OP_TYA = 6'd55, OP_ILL = 6'd63
	} op_t;

	localparam logic [7:0] FL_C = 8'h01;
	localparam logic [7:0] FL_Z = 8'h02;
	localparam logic [7:0] FL_I = 8'h04;
	localparam logic [7:0] FL_D = 8'h08;
	localparam logic [7:0] FL_B = 8'h10;
	localparam logic [7:0] FL_U = 8'h20;
	localparam logic [7:0] FL_V = 8'h40;
	localparam logic [7:0] FL_N = 8'h80;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET = 8'h24;
	localparam logic [7:0] STACK_PAGE = 8'h01;
	localparam int QDEPTH = 2;

	typedef struct packed {
		op_t cmd;
		logic [7:0] operand;
		logic [15:0] eff_address;
		logic [7:0] branch_offset;
		logic acc_mode;
		logic [7:0] aux0;
		logic [7:0] aux1;
		logic [7:0] aux2;
		logic pp;
	} ditem_t;

	function automatic op_t classify(input logic [5:0] c);
		classify = (c > 6'd55) ? OP_ILL : op_t'(c);
	endfunction

endpackage
`default_nettype wire

// File: src/cpu6502_instruction_execute_core.sv
`default_nettype none
// 6502 execute core. Each input beat is one decoded operation with its
// operand, effective address, branch offset and pre-read stack or vector
// bytes. A front stage classifies the command and places it in a
// two-entry queue; the back stage executes it against the architectural
// registers and loads an output register. Instructions that write memory
// give one output beat per write (BRK three, JSR two, stores, pushes and
// memory read-modify-write one); all others give a single beat. Every beat
// shows the register file after the whole instruction, and the final beat
// has last set. Throughput is one instruction per cycle when no writes are
// pending and out_ready is high, otherwise one per output beat. ADC and
// SBC are binary regardless of D.
module cpu6502_instruction_execute_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [5:0] cmd,
	input wire logic [7:0] operand,
	input wire logic [15:0] eff_address,
	input wire logic signed [7:0] branch_offset,
	input wire logic acc_mode,
	input wire logic [7:0] aux_byte0,
	input wire logic [7:0] aux_byte1,
	input wire logic [7:0] aux_byte2,
	output logic out_valid,
	input wire logic out_ready,
	output logic mem_write,
	output logic [15:0] write_address,
	output logic [7:0] write_data,
	output logic last,
	output logic [15:0] new_pc,
	output logic [7:0] acc_out,
	output logic [7:0] x_out,
	output logic [7:0] y_out,
	output logic [7:0] sp_out,
	output logic [7:0] status_out,
	output logic [1:0] branch_cycles,
	output logic page_penalty_ok
);
	c6502x_pkg::ditem_t q_item;
	logic q_valid, q_pop;

	// front: classify and queue
	c6502x_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .operand, .eff_address,
		.branch_offset, .acc_mode, .aux_byte0, .aux_byte1, .aux_byte2,
		.q_item, .q_valid, .q_pop
	);

	// back: execute and emit write beats
	c6502x_back u_back (
		.clk, .arst_n, .q_item, .q_valid, .q_pop, .out_valid, .out_ready,
		.mem_write, .write_address, .write_data, .last, .new_pc, .acc_out,
		.x_out, .y_out, .sp_out, .status_out, .branch_cycles, .page_penalty_ok
	);
endmodule
`default_nettype wire

// File: src/c6502x_front.sv
`default_nettype none
module c6502x_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [5:0] cmd,
	input wire logic [7:0] operand,
	input wire logic [15:0] eff_address,
	input wire logic signed [7:0] branch_offset,
	input wire logic acc_mode,
	input wire logic [7:0] aux_byte0,
	input wire logic [7:0] aux_byte1,
	input wire logic [7:0] aux_byte2,
	output c6502x_pkg::ditem_t q_item,
	output logic q_valid,
	input wire logic q_pop
);
	// two-entry queue decouples decode from execute
	c6502x_pkg::ditem_t mem_q [c6502x_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	c6502x_pkg::ditem_t d;
	logic push;

	always_comb begin
		d.cmd = c6502x_pkg::classify(cmd);
		d.operand = operand;
		d.eff_address = eff_address;
		d.branch_offset = branch_offset;
		d.acc_mode = acc_mode;
		d.aux0 = aux_byte0;
		d.aux1 = aux_byte1;
		d.aux2 = aux_byte2;
		case (d.cmd) inside
			c6502x_pkg::OP_ADC, c6502x_pkg::OP_AND, c6502x_pkg::OP_CMP, c6502x_pkg::OP_EOR,
			c6502x_pkg::OP_LDA, c6502x_pkg::OP_LDX, c6502x_pkg::OP_LDY, c6502x_pkg::OP_NOP,
			c6502x_pkg::OP_ORA, c6502x_pkg::OP_SBC: d.pp = 1'b1;
			default: d.pp = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// File: src/c6502x_back.sv
`default_nettype none
module c6502x_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire c6502x_pkg::ditem_t q_item,
	input wire logic q_valid,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic mem_write,
	output logic [15:0] write_address,
	output logic [7:0] write_data,
	output logic last,
	output logic [15:0] new_pc,
	output logic [7:0] acc_out,
	output logic [7:0] x_out,
	output logic [7:0] y_out,
	output logic [7:0] sp_out,
	output logic [7:0] status_out,
	output logic [1:0] branch_cycles,
	output logic page_penalty_ok
);
	logic [15:0] pc_q;
	logic [7:0] a_q, x_q, y_q, sp_q, p_q;

	// result register plus pending writes of a multi-beat instruction
	logic vld_q;
	logic [1:0] left_q;
	logic [15:0] wa_q [2];
	logic [7:0] wd_q [2];
	logic wsel_q;
	logic mw_q, last_q, pp_q;
	logic [15:0] ad_q;
	logic [7:0] dt_q;
	logic [1:0] bc_q;

	logic [15:0] pc_n;
	logic [7:0] a_n, x_n, y_n, sp_n, p_n, m, r, sum8;
	logic [8:0] sum, cmpd;
	logic [1:0] nw, bc;
	logic [15:0] wa [3];
	logic [7:0] wd [3];
	logic take, rmw, lastbeat, load;
	logic [15:0] tgt, pc1, pcm1, sp16;
	logic [7:0] cmpr;

	always_comb begin
		m = q_item.acc_mode ? a_q : q_item.operand;
		pc_n = pc_q; a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
		nw = 2'd0; bc = 2'd0; take = 1'b0; rmw = 1'b0; r = 8'h00; cmpr = a_q;
		cmpd = 9'h000;
		sp16 = {c6502x_pkg::STACK_PAGE, sp_q};
		for (int i = 0; i < 3; i++) begin
			wa[i] = 16'h0000;
			wd[i] = 8'h00;
		end
		sum = {1'b0, a_q} + {1'b0, (q_item.cmd == c6502x_pkg::OP_SBC) ? ~m : m}
			+ {8'h00, p_q[0]};
		sum8 = sum[7:0];
		tgt = pc_q + {{8{q_item.branch_offset[7]}}, q_item.branch_offset};
		pc1 = pc_q + 16'd1;
		pcm1 = pc_q - 16'd1;
		case (q_item.cmd)
			c6502x_pkg::OP_ADC, c6502x_pkg::OP_SBC: begin
				a_n = sum8;
				p_n[0] = sum[8];
				p_n[6] = ((q_item.cmd == c6502x_pkg::OP_SBC) ? ~(a_q[7] ^ ~m[7])
					: ~(a_q[7] ^ m[7])) & (a_q[7] ^ sum8[7]);
				p_n[1] = (sum8 == 8'h00); p_n[7] = sum8[7];
			end
			c6502x_pkg::OP_AND, c6502x_pkg::OP_EOR, c6502x_pkg::OP_ORA,
			c6502x_pkg::OP_LDA: begin
				case (q_item.cmd)
					c6502x_pkg::OP_AND: a_n = a_q & m;
					c6502x_pkg::OP_EOR: a_n = a_q ^ m;
					c6502x_pkg::OP_ORA: a_n = a_q | m;
					default: a_n = m;
				endcase
				p_n[1] = (a_n == 8'h00); p_n[7] = a_n[7];
			end
			c6502x_pkg::OP_ASL: begin rmw = 1'b1; r = {m[6:0], 1'b0}; p_n[0] = m[7]; end
			c6502x_pkg::OP_LSR: begin rmw = 1'b1; r = {1'b0, m[7:1]}; p_n[0] = m[0]; end
			c6502x_pkg::OP_ROL: begin rmw = 1'b1; r = {m[6:0], p_q[0]}; p_n[0] = m[7]; end
			c6502x_pkg::OP_ROR: begin rmw = 1'b1; r = {p_q[0], m[7:1]}; p_n[0] = m[0]; end
			c6502x_pkg::OP_DEC: begin rmw = 1'b1; r = m - 8'd1; end
			c6502x_pkg::OP_INC: begin rmw = 1'b1; r = m + 8'd1; end
			c6502x_pkg::OP_BCC: take = ~p_q[0];
			c6502x_pkg::OP_BCS: take = p_q[0];
			c6502x_pkg::OP_BEQ: take = p_q[1];
			c6502x_pkg::OP_BNE: take = ~p_q[1];
			c6502x_pkg::OP_BMI: take = p_q[7];
			c6502x_pkg::OP_BPL: take = ~p_q[7];
			c6502x_pkg::OP_BVC: take = ~p_q[6];
			c6502x_pkg::OP_BVS: take = p_q[6];
			c6502x_pkg::OP_BIT: begin
				p_n[1] = ((a_q & m) == 8'h00); p_n[7] = m[7]; p_n[6] = m[6];
			end
			c6502x_pkg::OP_BRK: begin
				nw = 2'd3;
				wa[0] = sp16; wd[0] = pc1[15:8];
				wa[1] = {c6502x_pkg::STACK_PAGE, sp_q - 8'd1}; wd[1] = pc1[7:0];
				wa[2] = {c6502x_pkg::STACK_PAGE, sp_q - 8'd2};
				wd[2] = p_q | c6502x_pkg::FL_B | c6502x_pkg::FL_U;
				sp_n = sp_q - 8'd3;
				p_n = p_q | c6502x_pkg::FL_I;
				pc_n = {q_item.aux1, q_item.aux0};
			end
			c6502x_pkg::OP_CLC: p_n = p_q & ~c6502x_pkg::FL_C;
			c6502x_pkg::OP_CLD: p_n = p_q & ~c6502x_pkg::FL_D;
			c6502x_pkg::OP_CLI: p_n = p_q & ~c6502x_pkg::FL_I;
			c6502x_pkg::OP_CLV: p_n = p_q & ~c6502x_pkg::FL_V;
			c6502x_pkg::OP_SEC: p_n = p_q | c6502x_pkg::FL_C;
			c6502x_pkg::OP_SED: p_n = p_q | c6502x_pkg::FL_D;
			c6502x_pkg::OP_SEI: p_n = p_q | c6502x_pkg::FL_I;
			c6502x_pkg::OP_CMP, c6502x_pkg::OP_CPX, c6502x_pkg::OP_CPY: begin
				case (q_item.cmd)
					c6502x_pkg::OP_CPX: cmpr = x_q;
					c6502x_pkg::OP_CPY: cmpr = y_q;
					default: cmpr = a_q;
				endcase
				cmpd = {1'b0, cmpr} - {1'b0, m};
				p_n[0] = ~cmpd[8]; p_n[1] = (cmpd[7:0] == 8'h00); p_n[7] = cmpd[7];
			end
			c6502x_pkg::OP_DEX: begin x_n = x_q - 8'd1; p_n[1] = (x_n == 8'h00); p_n[7] = x_n[7]; end
			c6502x_pkg::OP_DEY: begin y_n = y_q - 8'd1; p_n[1] = (y_n == 8'h00); p_n[7] = y_n[7]; end
			c6502x_pkg::OP_INX: begin x_n = x_q + 8'd1; p_n[1] = (x_n == 8'h00); p_n[7] = x_n[7]; end
			c6502x_pkg::OP_INY: begin y_n = y_q + 8'd1; p_n[1] = (y_n == 8'h00); p_n[7] = y_n[7]; end
			c6502x_pkg::OP_JMP: pc_n = q_item.eff_address;
			c6502x_pkg::OP_JSR: begin
				nw = 2'd2;
				wa[0] = sp16; wd[0] = pcm1[15:8];
				wa[1] = {c6502x_pkg::STACK_PAGE, sp_q - 8'd1};
				wd[1] = pcm1[7:0];
				sp_n = sp_q - 8'd2;
				pc_n = q_item.eff_address;
			end
			c6502x_pkg::OP_LDX: begin x_n = m; p_n[1] = (m == 8'h00); p_n[7] = m[7]; end
			c6502x_pkg::OP_LDY: begin y_n = m; p_n[1] = (m == 8'h00); p_n[7] = m[7]; end
			c6502x_pkg::OP_PHA: begin nw = 2'd1; wa[0] = sp16; wd[0] = a_q; sp_n = sp_q - 8'd1; end
			c6502x_pkg::OP_PHP: begin
				nw = 2'd1; wa[0] = sp16; wd[0] = p_q | c6502x_pkg::FL_B | c6502x_pkg::FL_U;
				sp_n = sp_q - 8'd1;
			end
			c6502x_pkg::OP_PLA: begin
				sp_n = sp_q + 8'd1; a_n = q_item.aux0;
				p_n[1] = (q_item.aux0 == 8'h00); p_n[7] = q_item.aux0[7];
			end
			c6502x_pkg::OP_PLP: begin
				sp_n = sp_q + 8'd1;
				p_n = (q_item.aux0 & ~c6502x_pkg::FL_B) | c6502x_pkg::FL_U;
			end
			c6502x_pkg::OP_RTI: begin
				sp_n = sp_q + 8'd3;
				p_n = (q_item.aux0 & ~c6502x_pkg::FL_B) | c6502x_pkg::FL_U;
				pc_n = {q_item.aux2, q_item.aux1};
			end
			c6502x_pkg::OP_RTS: begin
				sp_n = sp_q + 8'd2; pc_n = {q_item.aux1, q_item.aux0} + 16'd1;
			end
			c6502x_pkg::OP_STA: begin nw = 2'd1; wa[0] = q_item.eff_address; wd[0] = a_q; end
			c6502x_pkg::OP_STX: begin nw = 2'd1; wa[0] = q_item.eff_address; wd[0] = x_q; end
			c6502x_pkg::OP_STY: begin nw = 2'd1; wa[0] = q_item.eff_address; wd[0] = y_q; end
			c6502x_pkg::OP_TAX: begin x_n = a_q; p_n[1] = (a_q == 8'h00); p_n[7] = a_q[7]; end
			c6502x_pkg::OP_TAY: begin y_n = a_q; p_n[1] = (a_q == 8'h00); p_n[7] = a_q[7]; end
			c6502x_pkg::OP_TSX: begin x_n = sp_q; p_n[1] = (sp_q == 8'h00); p_n[7] = sp_q[7]; end
			c6502x_pkg::OP_TXA: begin a_n = x_q; p_n[1] = (x_q == 8'h00); p_n[7] = x_q[7]; end
			c6502x_pkg::OP_TYA: begin a_n = y_q; p_n[1] = (y_q == 8'h00); p_n[7] = y_q[7]; end
			c6502x_pkg::OP_TXS: sp_n = x_q;
			default: ;
		endcase
		if (rmw) begin
			p_n[1] = (r == 8'h00); p_n[7] = r[7];
			if (q_item.acc_mode) a_n = r;
			else begin nw = 2'd1; wa[0] = q_item.eff_address; wd[0] = r; end
		end
		if (take) begin
			pc_n = tgt;
			bc = (tgt[15:8] != pc_q[15:8]) ? 2'd2 : 2'd1;
		end
	end

	// output register empties or its last beat leaves; pending beats block the queue
	assign lastbeat = vld_q && out_ready && (left_q == 2'd0);
	assign q_pop = q_valid && (!vld_q || lastbeat);
	assign load = q_pop;

	assign out_valid = vld_q;
	assign mem_write = mw_q;
	assign write_address = ad_q;
	assign write_data = dt_q;
	assign last = last_q;
	assign new_pc = pc_q;
	assign acc_out = a_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign sp_out = sp_q;
	assign status_out = p_q;
	assign branch_cycles = bc_q;
	assign page_penalty_ok = pp_q;

	always_ff @(posedge clk) begin
		if (load) begin
			mw_q <= (nw != 2'd0);
			ad_q <= wa[0];
			dt_q <= wd[0];
			last_q <= (nw <= 2'd1);
			bc_q <= bc;
			pp_q <= q_item.pp;
			wa_q[0] <= wa[1]; wd_q[0] <= wd[1];
			wa_q[1] <= wa[2]; wd_q[1] <= wd[2];
		end else if (vld_q && out_ready && left_q != 2'd0) begin
			ad_q <= wa_q[wsel_q];
			dt_q <= wd_q[wsel_q];
			last_q <= (left_q == 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 16'h0000; a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00;
			sp_q <= c6502x_pkg::SP_RESET; p_q <= c6502x_pkg::P_RESET;
			vld_q <= 1'b0; left_q <= 2'd0; wsel_q <= 1'b0;
		end else if (load) begin
			pc_q <= pc_n; a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; p_q <= p_n;
			vld_q <= 1'b1;
			left_q <= (nw == 2'd0) ? 2'd0 : nw - 2'd1;
			wsel_q <= 1'b0;
		end else if (vld_q && out_ready) begin
			if (left_q == 2'd0) vld_q <= 1'b0;
			else begin
				left_q <= left_q - 2'd1;
				wsel_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: src/c6502x_chk.sv
`default_nettype none
module c6502x_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic mem_write,
	input wire logic last,
	input wire logic [7:0] status_out,
	input wire logic [15:0] new_pc,
	input wire logic [1:0] branch_cycles
);
	a_u_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_out[5] && !status_out[4]) else $error("U/B flag");
	a_nowrite_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mem_write |-> last) else $error("no-write beat not last");
	a_bc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> branch_cycles != 2'd3) else $error("branch cycles");
	a_mid_regs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && $stable(new_pc)
		&& $stable(status_out)) else $error("regs changed mid instruction");
endmodule

bind cpu6502_instruction_execute_core c6502x_chk u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .mem_write, .last, .status_out,
	.new_pc, .branch_cycles
);
`default_nettype wire
